/* src/rbcs_pkg.sv */
// ----------------------------------------------------------------------------
// rbcs_pkg
// Shared types, constants and saturating helpers for the rigid body contact
// step block.
// ----------------------------------------------------------------------------
package rbcs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
  localparam int DEN_BITS  = WORD_BITS + 1;
  localparam int CFG_BITS  = 17;
  localparam int NRM_BITS  = 18;
  localparam int DIV_CNT_BITS = $clog2(QUO_BITS + 1);
  localparam int SQ_CNT_BITS  = $clog2(WORD_BITS + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic        [WORD_BITS-1:0] umag_t;
  typedef logic signed [NRM_BITS-1:0]  nrm_t;
  typedef logic        [CFG_BITS-1:0]  cfg_t;

  localparam umag_t ONE_Q = umag_t'(1) << FRAC_BITS;
  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [PROD_BITS-1:0] MAG_LIM = PROD_BITS'(1) << (WORD_BITS - 1);

  localparam umag_t INV_MASS_RST      = umag_t'(65536);
  localparam cfg_t  RESTITUTION_RST   = cfg_t'(0);
  localparam cfg_t  FRICTION_RST      = cfg_t'(6554);
  localparam cfg_t  SLOPE_COS_RST     = cfg_t'(46341);
  localparam cfg_t  TANGENT_FLOOR_RST = cfg_t'(7);

  typedef enum logic [1:0] {
    KIND_INTEGRATE,
    KIND_FORCE,
    KIND_STATIC,
    KIND_BODY
  } kind_t;

  typedef enum logic [2:0] {
    REG_INV_MASS,
    REG_RESTITUTION,
    REG_FRICTION,
    REG_SLOPE_COS,
    REG_TANGENT_FLOOR
  } cfg_reg_t;

  function automatic word_t sat_mag(input logic neg, input logic [PROD_BITS-1:0] m);
    if (neg) begin
      if (m > MAG_LIM) return WORD_MIN;
      return word_t'(~m[WORD_BITS-1:0] + WORD_BITS'(1));
    end
    if (m > MAG_LIM - PROD_BITS'(1)) return WORD_MAX;
    return word_t'(m[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b, input logic sub);
    logic signed [WORD_BITS:0] s;
    s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
            : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic umag_t mag_of(input word_t v);
    return v[WORD_BITS-1] ? umag_t'(~v + WORD_BITS'(1)) : umag_t'(v);
  endfunction

endpackage

/* src/rigid_body_contact_step_top.sv */
// ----------------------------------------------------------------------------
// rigid_body_contact_step_top
// Q16.16 position and velocity of one body with impulse contact response.
// ----------------------------------------------------------------------------
// One transaction at a time: item_stall stays high from acceptance until the
// result is registered. A contact is sequenced through the shared multiplier,
// the shared divider (each quotient is a load followed by 48 quotient bits)
// and the square root. A body contact needs up to six quotients (share, normal
// impulse, friction impulse, three direction terms). The divider produces one
// quotient bit per cycle; a single 32x32 multiplier serves every product.
// The result register lets the next transaction be taken while the last
// result waits.
module rigid_body_contact_step_top
  import rbcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         kind,
  input  logic [30:0]        delta_time,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic [31:0]        other_inv_mass,
  input  logic signed [17:0] normal_x,
  input  logic signed [17:0] normal_y,
  input  logic signed [17:0] normal_z,
  input  logic [30:0]        penetration,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  output logic               resolved
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_INT_MUL, S_INT_ADD, S_FORCE, S_SHARE_DIV,
    S_D_MUL, S_D_SET, S_POS_MUL, S_POS_ADD, S_REL, S_VN_MUL, S_VN_ADD,
    S_IMP_CHECK, S_NUM_MUL, S_J_LOAD, S_J_DIV, S_IMP_MUL1, S_IMP_T,
    S_IMP_MUL2, S_IMP_ADD, S_FR_CHECK, S_VT_MUL, S_VT_SUB, S_SQ_MUL,
    S_SQ_ADD, S_SQRT_LOAD, S_SQRT, S_SPD_CHECK, S_JT_MUL, S_JT_LOAD,
    S_JT_DIV, S_DIR_LOAD, S_DIR_DIV, S_DIR_MUL1, S_DIR_T, S_DIR_MUL2,
    S_DIR_ADD, S_DONE
  } state_t;

  localparam logic [1:0] LAST_IDX = 2'd2;

  state_t state;

  umag_t inv_mass;
  cfg_t  restitution, friction, slope_cos, tangent_floor;

  kind_t             kind_q;
  logic [30:0]       dt_q;
  logic [30:0]       pen_q;
  umag_t             oim;
  word_t             oth [3];
  nrm_t              nrm [3];

  word_t             pos [3];
  word_t             vel [3];
  word_t             rel [3];
  word_t             vt  [3];
  word_t             vn, d, share, j, jt, tmp;
  logic [DEN_BITS-1:0]  total;
  umag_t             speed;
  logic [PROD_BITS-1:0] sum;
  logic [1:0]        idx;
  logic              hit;

  // shared multiplier
  umag_t mul_a, mul_b;
  logic  mul_neg;
  logic [PROD_BITS-1:0] prod;
  logic  prod_neg;
  word_t q_res;

  // shared divider
  logic                    div_load, div_load_neg;
  umag_t                   div_load_mag;
  logic [DEN_BITS-1:0]     div_load_den;
  logic [DEN_BITS-1:0]     div_rem, div_den;
  logic [QUO_BITS-1:0]     div_quo;
  logic                    div_neg;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [DEN_BITS:0]       div_sh, div_diff;
  logic                    div_ge;
  word_t                   div_res;

  // square root
  logic                    sq_load;
  logic [PROD_BITS-1:0]    sq_src;
  logic [WORD_BITS+1:0]    sq_rem;
  umag_t                   sq_res;
  logic [SQ_CNT_BITS-1:0]  sq_cnt;
  logic [WORD_BITS+3:0]    sq_sh, sq_trial, sq_diff;
  logic                    sq_ge;

  word_t                   n_w, other_c;
  logic [DEN_BITS-1:0]     total_c;

  assign item_stall = (state != S_IDLE);
  assign n_w        = word_t'(nrm[idx]);
  assign other_c    = (kind_q == KIND_BODY) ? oth[idx] : '0;
  assign total_c    = DEN_BITS'(inv_mass) + DEN_BITS'(oim);
  assign q_res      = sat_mag(prod_neg, prod >> FRAC_BITS);
  assign div_res    = sat_mag(div_neg, PROD_BITS'(div_quo));

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state) inside
      S_INT_MUL: begin
        mul_a   = mag_of(vel[idx]);
        mul_b   = umag_t'(dt_q);
        mul_neg = vel[idx][WORD_BITS-1];
      end
      S_D_MUL: begin
        mul_a = umag_t'(pen_q);
        mul_b = mag_of(share);
      end
      S_POS_MUL: begin
        mul_a   = mag_of(n_w);
        mul_b   = mag_of(d);
        mul_neg = n_w[WORD_BITS-1] ^ d[WORD_BITS-1];
      end
      S_VN_MUL: begin
        mul_a   = mag_of(rel[idx]);
        mul_b   = mag_of(n_w);
        mul_neg = rel[idx][WORD_BITS-1] ^ n_w[WORD_BITS-1];
      end
      S_NUM_MUL: begin
        mul_a = ONE_Q + umag_t'(restitution);
        mul_b = mag_of(vn);
      end
      S_IMP_MUL1: begin
        mul_a   = mag_of(n_w);
        mul_b   = mag_of(j);
        mul_neg = n_w[WORD_BITS-1] ^ j[WORD_BITS-1];
      end
      S_VT_MUL: begin
        mul_a   = mag_of(vn);
        mul_b   = mag_of(n_w);
        mul_neg = vn[WORD_BITS-1] ^ n_w[WORD_BITS-1];
      end
      S_SQ_MUL: begin
        mul_a = mag_of(vt[idx]);
        mul_b = mag_of(vt[idx]);
      end
      S_JT_MUL: begin
        mul_a = speed;
        mul_b = umag_t'(friction);
      end
      S_DIR_MUL1: begin
        mul_a   = mag_of(tmp);
        mul_b   = mag_of(jt);
        mul_neg = tmp[WORD_BITS-1] ^ jt[WORD_BITS-1];
      end
      S_IMP_MUL2, S_DIR_MUL2: begin
        mul_a   = mag_of(tmp);
        mul_b   = inv_mass;
        mul_neg = tmp[WORD_BITS-1];
      end
      default: ;
    endcase
  end

  always_comb begin
    div_load     = 1'b0;
    div_load_mag = '0;
    div_load_neg = 1'b0;
    div_load_den = '0;
    case (state)
      S_DISPATCH: begin
        div_load     = 1'b1;
        div_load_mag = inv_mass;
        div_load_den = total_c;
      end
      S_J_LOAD: begin
        div_load     = 1'b1;
        div_load_mag = mag_of(q_res);
        div_load_den = total;
      end
      S_JT_LOAD: begin
        div_load     = 1'b1;
        div_load_mag = mag_of(q_res);
        div_load_den = DEN_BITS'(inv_mass);
      end
      S_DIR_LOAD: begin
        div_load     = 1'b1;
        div_load_mag = mag_of(vt[idx]);
        div_load_neg = vt[idx][WORD_BITS-1];
        div_load_den = DEN_BITS'(speed);
      end
      default: ;
    endcase
  end

  assign sq_load  = (state == S_SQRT_LOAD);
  assign div_sh   = {div_rem, div_quo[QUO_BITS-1]};
  assign div_diff = div_sh - {1'b0, div_den};
  assign div_ge   = (div_sh >= {1'b0, div_den});
  assign sq_sh    = {sq_rem, sq_src[PROD_BITS-1 -: 2]};
  assign sq_trial = {2'b00, sq_res, 2'b01};
  assign sq_diff  = sq_sh - sq_trial;
  assign sq_ge    = (sq_sh >= sq_trial);

  always_ff @(posedge clk) begin
    prod     <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    prod_neg <= mul_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_load) begin
      div_rem <= '0;
      div_quo <= {div_load_mag, {FRAC_BITS{1'b0}}};
      div_den <= div_load_den;
      div_neg <= div_load_neg;
      div_cnt <= DIV_CNT_BITS'(QUO_BITS);
    end else if (div_cnt != '0) begin
      div_rem <= div_ge ? div_diff[DEN_BITS-1:0] : div_sh[DEN_BITS-1:0];
      div_quo <= {div_quo[QUO_BITS-2:0], div_ge};
      div_cnt <= div_cnt - DIV_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if (sq_load) begin
      sq_src <= sum;
      sq_rem <= '0;
      sq_res <= '0;
      sq_cnt <= SQ_CNT_BITS'(WORD_BITS);
    end else if (sq_cnt != '0) begin
      sq_rem <= sq_ge ? sq_diff[WORD_BITS+1:0] : sq_sh[WORD_BITS+1:0];
      sq_res <= {sq_res[WORD_BITS-2:0], sq_ge};
      sq_src <= {sq_src[PROD_BITS-3:0], 2'b00};
      sq_cnt <= sq_cnt - SQ_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      inv_mass      <= INV_MASS_RST;
      restitution   <= RESTITUTION_RST;
      friction      <= FRICTION_RST;
      slope_cos     <= SLOPE_COS_RST;
      tangent_floor <= TANGENT_FLOOR_RST;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_INV_MASS:      inv_mass      <= cfg_data;
          REG_RESTITUTION:   restitution   <= cfg_data[CFG_BITS-1:0];
          REG_FRICTION:      friction      <= cfg_data[CFG_BITS-1:0];
          REG_SLOPE_COS:     slope_cos     <= cfg_data[CFG_BITS-1:0];
          REG_TANGENT_FLOOR: tangent_floor <= cfg_data[CFG_BITS-1:0];
          default: ;
        endcase
      end

      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            kind_q <= kind_t'(kind);
            dt_q   <= delta_time;
            pen_q  <= penetration;
            oim    <= other_inv_mass;
            oth[0] <= vec_x;
            oth[1] <= vec_y;
            oth[2] <= vec_z;
            nrm[0] <= normal_x;
            nrm[1] <= normal_y;
            nrm[2] <= normal_z;
            idx    <= '0;
            vn     <= '0;
            hit    <= 1'b0;
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (kind_q)
            KIND_INTEGRATE: state <= S_INT_MUL;
            KIND_FORCE:     state <= S_FORCE;
            KIND_STATIC: begin
              if (inv_mass == '0) begin
                state <= S_DONE;
              end else begin
                total <= DEN_BITS'(inv_mass);
                share <= word_t'(ONE_Q);
                hit   <= 1'b1;
                state <= S_D_MUL;
              end
            end
            KIND_BODY: begin
              if (total_c == '0) begin
                state <= S_DONE;
              end else begin
                total <= total_c;
                hit   <= 1'b1;
                state <= S_SHARE_DIV;
              end
            end
          endcase
        end
        S_INT_MUL: state <= S_INT_ADD;
        S_INT_ADD: begin
          pos[idx] <= sat_add(pos[idx], q_res, 1'b0);
          idx      <= idx + 2'd1;
          state    <= (idx == LAST_IDX) ? S_DONE : S_INT_MUL;
        end
        S_FORCE: begin
          vel[idx] <= sat_add(vel[idx], oth[idx], 1'b0);
          idx      <= idx + 2'd1;
          if (idx == LAST_IDX) state <= S_DONE;
        end
        S_SHARE_DIV: begin
          if (div_cnt == '0) begin
            share <= div_res;
            state <= S_D_MUL;
          end
        end
        S_D_MUL: state <= S_D_SET;
        S_D_SET: begin
          d     <= q_res;
          idx   <= '0;
          state <= S_POS_MUL;
        end
        S_POS_MUL: state <= S_POS_ADD;
        S_POS_ADD: begin
          pos[idx] <= sat_add(pos[idx], q_res, 1'b0);
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_REL;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_POS_MUL;
          end
        end
        S_REL: begin
          rel[idx] <= sat_add(vel[idx], other_c, 1'b1);
          state    <= S_VN_MUL;
        end
        S_VN_MUL: state <= S_VN_ADD;
        S_VN_ADD: begin
          vn <= sat_add(vn, q_res, 1'b0);
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IMP_CHECK;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_REL;
          end
        end
        S_IMP_CHECK: state <= vn[WORD_BITS-1] ? S_NUM_MUL : S_FR_CHECK;
        S_NUM_MUL:   state <= S_J_LOAD;
        S_J_LOAD:    state <= S_J_DIV;
        S_J_DIV: begin
          if (div_cnt == '0) begin
            j     <= div_res;
            idx   <= '0;
            state <= S_IMP_MUL1;
          end
        end
        S_IMP_MUL1: state <= S_IMP_T;
        S_IMP_T: begin
          tmp   <= q_res;
          state <= S_IMP_MUL2;
        end
        S_IMP_MUL2: state <= S_IMP_ADD;
        S_IMP_ADD: begin
          vel[idx] <= sat_add(vel[idx], q_res, 1'b0);
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_FR_CHECK;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_IMP_MUL1;
          end
        end
        S_FR_CHECK: begin
          idx <= '0;
          sum <= '0;
          if ((nrm[1] >= $signed({1'b0, slope_cos})) && (inv_mass != '0)) begin
            state <= S_VT_MUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_VT_MUL: state <= S_VT_SUB;
        S_VT_SUB: begin
          vt[idx] <= sat_add(rel[idx], q_res, 1'b1);
          state   <= S_SQ_MUL;
        end
        S_SQ_MUL: state <= S_SQ_ADD;
        S_SQ_ADD: begin
          sum <= sum + prod;
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_SQRT_LOAD;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_VT_MUL;
          end
        end
        S_SQRT_LOAD: state <= S_SQRT;
        S_SQRT: begin
          if (sq_cnt == '0) begin
            speed <= sq_res;
            state <= S_SPD_CHECK;
          end
        end
        S_SPD_CHECK: state <= (speed > umag_t'(tangent_floor)) ? S_JT_MUL : S_DONE;
        S_JT_MUL:    state <= S_JT_LOAD;
        S_JT_LOAD:   state <= S_JT_DIV;
        S_JT_DIV: begin
          if (div_cnt == '0) begin
            jt    <= -div_res;
            idx   <= '0;
            state <= S_DIR_LOAD;
          end
        end
        S_DIR_LOAD: state <= S_DIR_DIV;
        S_DIR_DIV: begin
          if (div_cnt == '0) begin
            tmp   <= div_res;
            state <= S_DIR_MUL1;
          end
        end
        S_DIR_MUL1: state <= S_DIR_T;
        S_DIR_T: begin
          tmp   <= q_res;
          state <= S_DIR_MUL2;
        end
        S_DIR_MUL2: state <= S_DIR_ADD;
        S_DIR_ADD: begin
          vel[idx] <= sat_add(vel[idx], q_res, 1'b0);
          if (idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_DIR_LOAD;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            pos_x        <= pos[0];
            pos_y        <= pos[1];
            pos_z        <= pos[2];
            vel_x        <= vel[0];
            vel_y        <= vel[1];
            vel_z        <= vel[2];
            resolved     <= hit;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* dv/tb_rigid_body_contact_step_top.sv */
// ----------------------------------------------------------------------------
// tb_rigid_body_contact_step_top
// Self-checking testbench for the rigid body contact step block. A local
// fixed point model predicts position, velocity and the resolved flag for
// every accepted transaction; results are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_rigid_body_contact_step_top
  import rbcs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LIMIT_CYCLES = 5000000;

  typedef struct {
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic               res;
  } body_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] kind = '0;
  logic [30:0] delta_time = '0;
  logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic [31:0] other_inv_mass = '0;
  logic signed [17:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic [30:0] penetration = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  logic resolved;

  rigid_body_contact_step_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state and registers
  longint m_pos[3], m_vel[3];
  longint unsigned r_im, r_rest, r_fric, r_slope, r_floor;
  body_state_t expected_q[$];
  int errors = 0;
  longint cycles = 0;
  bit stall_random = 1'b1;

  localparam longint WMAXL = 64'sd2147483647;
  localparam longint WMINL = -64'sd2147483648;

  function automatic longint clamp(longint v);
    if (v > WMAXL) return WMAXL;
    if (v < WMINL) return WMINL;
    return v;
  endfunction

  function automatic longint clamp_wide(logic signed [129:0] v);
    if (v > 130'sd2147483647) return WMAXL;
    if (v < -130'sd2147483648) return WMINL;
    return longint'(v);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic signed [129:0] p;
    p = 130'(a) * 130'(b);
    if (p < 0) p = -((-p) >>> 16);
    else p = p >>> 16;
    return clamp_wide(p);
  endfunction

  function automatic longint fx_div(longint a, longint unsigned b);
    logic signed [129:0] n, q;
    n = 130'(a) <<< 16;
    if (n < 0) q = -((-n) / 130'(b));
    else q = n / 130'(b);
    return clamp_wide(q);
  endfunction

  function automatic longint unsigned root_floor(logic [129:0] n);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd1 << 50;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (130'(mid) * 130'(mid) <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic apply_contact(longint oth[3], longint unsigned total, longint share,
                               longint nv[3], longint pen);
    longint rel[3], vt[3], vn, d, num, j, jt, dir;
    logic [129:0] sum;
    longint unsigned speed;
    vn = 0;
    d = fx_mul(pen, share);
    for (int i = 0; i < 3; i++) m_pos[i] = clamp(m_pos[i] + fx_mul(nv[i], d));
    for (int i = 0; i < 3; i++) begin
      rel[i] = clamp(m_vel[i] - oth[i]);
      vn = clamp(vn + fx_mul(rel[i], nv[i]));
    end
    if (vn < 0) begin
      num = fx_mul(65536 + longint'(r_rest), -vn);
      j = fx_div(num, total);
      for (int i = 0; i < 3; i++)
        m_vel[i] = clamp(m_vel[i] + fx_mul(fx_mul(nv[i], j), longint'(r_im)));
    end
    if (nv[1] >= longint'(r_slope) && r_im != 0) begin
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        vt[i] = clamp(rel[i] - fx_mul(vn, nv[i]));
        sum += 130'(vt[i] * vt[i]);
      end
      speed = root_floor(sum);
      if (speed > r_floor) begin
        jt = -fx_div(fx_mul(longint'(speed), longint'(r_fric)), r_im);
        for (int i = 0; i < 3; i++) begin
          dir = fx_div(vt[i], speed);
          m_vel[i] = clamp(m_vel[i] + fx_mul(fx_mul(dir, jt), longint'(r_im)));
        end
      end
    end
  endtask

  task automatic predict_step(logic [1:0] k, logic [30:0] dt, logic signed [31:0] vx,
                              logic signed [31:0] vy, logic signed [31:0] vz,
                              logic [31:0] oim, logic signed [17:0] nx,
                              logic signed [17:0] ny, logic signed [17:0] nz,
                              logic [30:0] pen);
    longint vec[3], nv[3], zero[3];
    longint unsigned total;
    body_state_t e;
    vec = '{longint'(vx), longint'(vy), longint'(vz)};
    nv = '{longint'(nx), longint'(ny), longint'(nz)};
    zero = '{0, 0, 0};
    e.res = 1'b0;
    case (kind_t'(k))
      KIND_INTEGRATE: for (int i = 0; i < 3; i++)
        m_pos[i] = clamp(m_pos[i] + fx_mul(m_vel[i], longint'(dt)));
      KIND_FORCE: for (int i = 0; i < 3; i++) m_vel[i] = clamp(m_vel[i] + vec[i]);
      KIND_STATIC: if (r_im != 0) begin
        apply_contact(zero, r_im, 65536, nv, longint'(pen));
        e.res = 1'b1;
      end
      default: begin
        total = r_im + longint'(oim);
        if (total != 0) begin
          apply_contact(vec, total, fx_div(longint'(r_im), total), nv, longint'(pen));
          e.res = 1'b1;
        end
      end
    endcase
    e.px = m_pos[0][31:0]; e.py = m_pos[1][31:0]; e.pz = m_pos[2][31:0];
    e.vx = m_vel[0][31:0]; e.vy = m_vel[1][31:0]; e.vz = m_vel[2][31:0];
    expected_q.push_back(e);
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 4);
  endfunction

  task automatic send_item(logic [1:0] k, logic [30:0] dt, logic signed [31:0] vx,
                           logic signed [31:0] vy, logic signed [31:0] vz,
                           logic [31:0] oim, logic signed [17:0] nx,
                           logic signed [17:0] ny, logic signed [17:0] nz,
                           logic [30:0] pen, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      item_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k; delta_time <= dt; vec_x <= vx; vec_y <= vy; vec_z <= vz;
    other_inv_mass <= oim; normal_x <= nx; normal_y <= ny; normal_z <= nz;
    penetration <= pen;
    predict_step(k, dt, vx, vy, vz, oim, nx, ny, nz, pen);
    do @(posedge clk); while (item_stall);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_INV_MASS: r_im = v;
      REG_RESTITUTION: r_rest = v[16:0];
      REG_FRICTION: r_fric = v[16:0];
      REG_SLOPE_COS: r_slope = v[16:0];
      default: r_floor = v[16:0];
    endcase
  endtask

  task automatic set_config(logic [31:0] im, logic [16:0] re, logic [16:0] fr,
                            logic [16:0] sl, logic [16:0] fl);
    wait_idle();
    write_reg(REG_INV_MASS, im);
    write_reg(REG_RESTITUTION, 32'(re));
    write_reg(REG_FRICTION, 32'(fr));
    write_reg(REG_SLOPE_COS, 32'(sl));
    write_reg(REG_TANGENT_FLOOR, 32'(fl));
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic signed [17:0] rand_normal();
    case ($urandom_range(0, 4))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'($urandom);
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
    endcase
  endfunction

  task automatic random_item(bit gaps);
    logic [1:0] k;
    logic [30:0] dt, pen;
    k = 2'($urandom);
    dt = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 16));
    pen = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 17));
    send_item(k, dt, rand_word(), rand_word(), rand_word(),
              $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1 << 17),
              rand_normal(), rand_normal(), rand_normal(), pen, gaps);
  endtask

  task automatic test_directed();
    send_item(KIND_FORCE, 0, 32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 0, 0, 0, 0, 0, 0);
    send_item(KIND_INTEGRATE, 31'h7fffffff, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_INTEGRATE, 31'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_STATIC, 0, 0, 0, 0, 0, 0, 18'sd65536, 0, 31'h0000_4000, 0);
    send_item(KIND_STATIC, 0, 0, 0, 0, 0, 18'sd46341, 18'sd46341, 0, 31'h7fffffff, 0);
    send_item(KIND_FORCE, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, 0, 0);
    send_item(KIND_FORCE, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0, 0, 0);
    send_item(KIND_BODY, 0, 32'sh0003_0000, 32'sh0001_0000, -32'sh0001_0000, 32'hffffffff,
              -18'sd65536, 18'sd65536, -18'sd65536, 31'h0001_0000, 0);
    send_item(KIND_BODY, 0, 0, 0, 0, 0, 18'sd131071, -18'sd131072, 18'sd1, 1, 0);
    send_item(KIND_INTEGRATE, 31'h0000_8000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    set_config(0, 17'd65536, 17'd65536, 0, 17'd65536);
    send_item(KIND_STATIC, 0, 1, 2, 3, 5, 0, 18'sd65536, 0, 31'h0001_0000, 0);
    send_item(KIND_BODY, 0, 0, 0, 0, 0, 0, 18'sd65536, 0, 31'h0001_0000, 0);
    send_item(KIND_BODY, 0, 32'sh0005_0000, -32'sh0005_0000, 32'sh0001_0000, 32'h0001_0000,
              0, 18'sd65536, 0, 31'h0001_0000, 0);
    set_config(32'hffffffff, 17'd65536, 17'd65536, 0, 0);
    send_item(KIND_FORCE, 0, 32'sh0010_0000, -32'sh0010_0000, 32'sh0003_0000, 0, 0, 0, 0, 0, 0);
    send_item(KIND_STATIC, 0, 0, 0, 0, 0, 0, 18'sd65536, 0, 31'h0000_0100, 0);
    send_item(KIND_BODY, 0, -32'sh0001_0000, 0, 0, 32'hffffffff, 18'sd65536, 0, 0, 1, 0);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) random_item(1'b1);
  endtask

  task automatic test_config_sweep();
    set_config(32'h0001_0000, 0, 17'd6554, 17'd46341, 17'd7);
    test_random(400);
    set_config(32'h0000_0100, 17'd32768, 17'd65536, 0, 0);
    test_random(400);
    set_config(32'h0004_0000, 17'd65536, 17'd16384, 17'd65536, 17'd65536);
    test_random(400);
    set_config($urandom, 17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
               17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
    test_random(430);
  endtask

  initial begin
    r_im = 65536; r_rest = 0; r_fric = 6554; r_slope = 46341; r_floor = 7;
    for (int i = 0; i < 3; i++) begin
      m_pos[i] = 0;
      m_vel[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    wait_idle();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_random) result_stall <= gap_len() != 0;
    else result_stall <= 1'b0;
    if ($urandom_range(0, 499) == 0) stall_random <= ~stall_random;
  end

  always @(posedge clk) begin
    body_state_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with no pending transaction");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (pos_x !== e.px) begin $error("pos_x exp %h got %h", e.px, pos_x); errors++; end
        if (pos_y !== e.py) begin $error("pos_y exp %h got %h", e.py, pos_y); errors++; end
        if (pos_z !== e.pz) begin $error("pos_z exp %h got %h", e.pz, pos_z); errors++; end
        if (vel_x !== e.vx) begin $error("vel_x exp %h got %h", e.vx, vel_x); errors++; end
        if (vel_y !== e.vy) begin $error("vel_y exp %h got %h", e.vy, vel_y); errors++; end
        if (vel_z !== e.vz) begin $error("vel_z exp %h got %h", e.vz, vel_z); errors++; end
        if (resolved !== e.res) begin
          $error("resolved exp %b got %b", e.res, resolved);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

/* rigid_body_contact_step_top.f */
src/rbcs_pkg.sv
src/rigid_body_contact_step_top.sv
dv/tb_rigid_body_contact_step_top.sv
